[hdl/tml_pkg.sv]
`default_nettype none
package tml_pkg;

  localparam int WINDOW    = 5;
  localparam int WIN_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WIN_CNT_W = $clog2(WINDOW + 1);

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 10;
  localparam int REG_W    = 16;
  localparam int TEMP_W   = 20;
  localparam int LN_W     = 13;
  localparam int LN_DEPTH = 1 << SAMPLE_W;
  localparam int PROD_W   = LN_W + 1 + REG_W;
  localparam int MAG_W    = PROD_W - 1;
  localparam int QUOT_W   = 15;

  localparam int READ_GAP    = 1000;
  localparam int ERR_LOW     = 5;
  localparam int ERR_HIGH    = 1020;
  localparam int IGNORE_TEMP = 20000;

  // floor(x / 10000) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2^28
  localparam int DIV_SHIFT = 42;
  localparam int RECIP_W   = 29;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 29'd439804652;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE     = 2'd2;

  localparam logic [REG_W-1:0] MULT_RESET = 16'd1000;

  typedef struct packed {
    logic load_in;
    logic commit;
    logic med_step;
    logic rom_rd;
    logic mul;
    logic div;
    logic fin;
  } tml_cmd_t;

  typedef struct packed {
    logic gap_ok;
    logic med_found;
  } tml_stat_t;

  typedef logic [LN_W-1:0] ln_rom_t [LN_DEPTH];

  // log table build, elaboration only
  localparam int LOG_F = 60;
  localparam logic [191:0] LN2_E21 = 192'd693147180559945309417;
  localparam logic [191:0] DEC_E18 = 192'd1000000000000000000;

  function automatic logic [LN_W-1:0] ln_milli_calc(input int n);
    logic [127:0] x;
    logic [191:0] y;
    logic [191:0] r;
    int k;
    k = 0;
    x = '0;
    y = '0;
    r = '0;
    if (n > 1) begin
      for (int b = 0; b < SAMPLE_W; b++) begin
        if ((n >> b) != 0) k = b;
      end
      x = 128'(n) << (LOG_F - k);
      y = 192'(k) << LOG_F;
      for (int i = LOG_F - 1; i >= 0; i--) begin
        x = (x * x) >> LOG_F;
        if (x[LOG_F+1]) begin
          x = x >> 1;
          y[i] = 1'b1;
        end
      end
      r = ((y * LN2_E21) >> LOG_F) / DEC_E18;
    end
    return r[LN_W-1:0];
  endfunction

  function automatic ln_rom_t ln_rom_build();
    ln_rom_t t;
    for (int i = 0; i < LN_DEPTH; i++) begin
      t[i] = ln_milli_calc(i);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

[hdl/tml_in_if.sv]
`default_nettype none
interface tml_in_if;
  import tml_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output now_ms, output adc_sample, input ready);
  modport sink   (input valid, input now_ms, input adc_sample, output ready);
endinterface
`default_nettype wire

[hdl/tml_out_if.sv]
`default_nettype none
interface tml_out_if;
  import tml_pkg::*;

  logic                valid;
  logic                ready;
  logic [TEMP_W-1:0]   milli_celsius;
  logic                sensor_error;
  logic [SAMPLE_W-1:0] median_sample;

  modport source (output valid, output milli_celsius, output sensor_error,
                  output median_sample, input ready);
  modport sink   (input valid, input milli_celsius, input sensor_error,
                  input median_sample, output ready);
endinterface
`default_nettype wire

[hdl/tml_ctrl.sv]
`default_nettype none
module tml_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire tml_pkg::tml_stat_t stat,
  output tml_pkg::tml_cmd_t       cmd
);
  import tml_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_MED,
    S_ROM,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && in_valid && in_ready;
    cmd.commit   = (state == S_GAP) && stat.gap_ok;
    cmd.med_step = (state == S_MED);
    cmd.rom_rd   = (state == S_ROM);
    cmd.mul      = (state == S_MUL);
    cmd.div      = (state == S_DIV);
    cmd.fin      = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load_in) begin
            state    <= S_GAP;
            in_ready <= 1'b0;
          end
        end
        S_GAP: begin
          if (stat.gap_ok) begin
            state <= S_MED;
          end else begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_MED: begin
          if (stat.med_found) state <= S_ROM;
        end
        S_ROM: state <= S_MUL;
        S_MUL: state <= S_DIV;
        S_DIV: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/tml_dp.sv]
`default_nettype none
module tml_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tml_pkg::REG_W-1:0]     cfg_data,
  input  wire logic [tml_pkg::TIME_W-1:0]    now_ms,
  input  wire logic [tml_pkg::SAMPLE_W-1:0]  adc_sample,
  input  wire tml_pkg::tml_cmd_t             cmd,
  output tml_pkg::tml_stat_t                 stat,
  output logic [tml_pkg::TEMP_W-1:0]         milli_celsius,
  output logic                               sensor_error,
  output logic [tml_pkg::SAMPLE_W-1:0]       median_sample
);
  import tml_pkg::*;

  localparam ln_rom_t LN_ROM = ln_rom_build();

  logic signed [REG_W-1:0]  multiplier;
  logic signed [REG_W-1:0]  offset;
  logic                     ignore_sensor;

  logic [TIME_W-1:0]        now_r;
  logic [SAMPLE_W-1:0]      sample_r;
  logic [TIME_W-1:0]        last_read_time;
  logic [SAMPLE_W-1:0]      window [WINDOW];
  logic [WIN_CNT_W-1:0]     fill;
  logic [WIN_IDX_W-1:0]     ptr;
  logic [WIN_IDX_W-1:0]     cand;
  logic [SAMPLE_W-1:0]      med;
  logic [LN_W-1:0]          rom_q;
  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic [MAG_W+RECIP_W-1:0] quot_full;

  logic [TIME_W-1:0]        gap;
  logic [SAMPLE_W-1:0]      cand_val;
  logic [WIN_CNT_W-1:0]     lt_cnt;
  logic [WIN_CNT_W-1:0]     le_cnt;
  logic [WIN_CNT_W-1:0]     half;
  logic [MAG_W-1:0]         mag;
  logic [QUOT_W-1:0]        quot;
  logic [REG_W-1:0]         quot_s;
  logic [REG_W-1:0]         scaled;
  logic [TEMP_W-1:0]        scaled_x;
  logic [TEMP_W-1:0]        temp;

  assign gap         = now_r - last_read_time;
  assign stat.gap_ok = gap > TIME_W'(READ_GAP);

  // rank of the candidate among the filled entries
  always_comb begin
    cand_val = window[cand];
    lt_cnt   = '0;
    le_cnt   = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (WIN_CNT_W'(j) < fill) begin
        if (window[j] < cand_val)  lt_cnt = lt_cnt + 1'b1;
        if (window[j] <= cand_val) le_cnt = le_cnt + 1'b1;
      end
    end
  end

  assign half           = fill >> 1;
  assign stat.med_found = (lt_cnt <= half) && (half < le_cnt);

  assign mag      = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
  assign quot     = quot_full[DIV_SHIFT +: QUOT_W];
  assign quot_s   = neg ? -REG_W'(quot) : REG_W'(quot);
  assign scaled   = quot_s + offset;
  assign scaled_x = {{(TEMP_W-REG_W){scaled[REG_W-1]}}, scaled};
  assign temp     = (scaled_x << 3) + (scaled_x << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier     <= MULT_RESET;
      offset         <= '0;
      ignore_sensor  <= 1'b0;
      last_read_time <= '0;
      fill           <= '0;
      ptr            <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MULTIPLIER: multiplier    <= cfg_data;
          REG_OFFSET:     offset        <= cfg_data;
          REG_IGNORE:     ignore_sensor <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        last_read_time <= now_r;
        ptr            <= (ptr == WIN_IDX_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;
        if (fill < WIN_CNT_W'(WINDOW)) fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r    <= now_ms;
      sample_r <= adc_sample;
    end
    if (cmd.commit) begin
      window[ptr] <= sample_r;
      cand        <= '0;
    end
    if (cmd.med_step) begin
      if (stat.med_found) med  <= cand_val;
      else                cand <= cand + 1'b1;
    end
    if (cmd.rom_rd) rom_q <= LN_ROM[med];
    if (cmd.mul) prod <= $signed({1'b0, rom_q}) * multiplier;
    if (cmd.div) begin
      neg       <= prod[PROD_W-1];
      quot_full <= mag * DIV_RECIP;
    end
    if (cmd.fin) begin
      median_sample <= med;
      if (ignore_sensor) begin
        milli_celsius <= TEMP_W'(IGNORE_TEMP);
        sensor_error  <= 1'b0;
      end else begin
        milli_celsius <= temp;
        sensor_error  <= (sample_r < SAMPLE_W'(ERR_LOW)) ||
                         (sample_r > SAMPLE_W'(ERR_HIGH));
      end
    end
  end
endmodule
`default_nettype wire

[hdl/thermistor_median_log_temperature.sv]
// Sequence: input beat, read-gap check, then median candidates k = 1..WINDOW tried
//   one per cycle against the filled window entries, then log lookup, multiply, divide.
// A read that is too soon gives no result. A new input beat is taken only once the
//   last one is dropped or its result is loaded into the output register.
// Reset (synchronous, active high): registers to defaults, window empty,
//   last read time zero, no result pending.
`default_nettype none
module thermistor_median_log_temperature (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tml_pkg::REG_W-1:0]     cfg_data,
  tml_in_if.sink                             reading,
  tml_out_if.source                          result
);
  import tml_pkg::*;

  tml_cmd_t  cmd;
  tml_stat_t stat;

  tml_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (reading.valid),
    .in_ready  (reading.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tml_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .now_ms        (reading.now_ms),
    .adc_sample    (reading.adc_sample),
    .cmd           (cmd),
    .stat          (stat),
    .milli_celsius (result.milli_celsius),
    .sensor_error  (result.sensor_error),
    .median_sample (result.median_sample)
  );

  a_commit_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(cmd.load_in))
    else $error("window commit without a preceding input beat");

  a_rom_after_median: assert property (@(posedge clk) disable iff (rst)
    cmd.rom_rd |-> $past(stat.med_found))
    else $error("log lookup before median was found");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.med_step |-> !reading.ready)
    else $error("input ready while median search runs");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.fin))
    else $error("result beat raised without a finished conversion");
endmodule
`default_nettype wire

[verif/tb_thermistor_median_log_temperature.sv]
`timescale 1ns / 100ps
module tb_thermistor_median_log_temperature;
  import tml_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_TAIL    = 40;
  localparam int LONG_HOLD     = 400;
  localparam int N_PHASES      = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] milli_celsius;
    logic                     sensor_error;
    logic [SAMPLE_W-1:0]      median_sample;
  } temp_result_t;

  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [TIME_W-1:0]    now;
    logic [SAMPLE_W-1:0]  sample;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [REG_W-1:0]     cfg_val;
    temp_result_t         typed;
  } dir_row_t;

  localparam temp_result_t NO_TEMP = '{20'sd0, 1'b0, 10'd0};
  localparam temp_result_t LOW_ERR = '{20'sd0, 1'b1, 10'd1};

  dir_row_t plan [27] = '{
    '{ROW_NONE,  32'd1000,       10'd600,  REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_TYPED, 32'd1001,       10'd1,    REG_NONE,       16'h0000, LOW_ERR},
    '{ROW_NONE,  32'd1500,       10'd900,  REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_TYPED, 32'd2002,       10'd0,    REG_NONE,       16'h0000, LOW_ERR},
    '{ROW_TYPED, 32'd3003,       10'd1023, REG_NONE,       16'h0000, LOW_ERR},
    '{ROW_PRED,  32'd4004,       10'd1020, REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd5005,       10'd5,    REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd6006,       10'd4,    REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd7007,       10'd1021, REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'hFFFF_FFFF,  10'd512,  REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_NONE,  32'd999,        10'd300,  REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd1000,       10'd700,  REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_MULTIPLIER, 16'h7FFF, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_OFFSET,     16'h7FFF, NO_TEMP},
    '{ROW_PRED,  32'd2001,       10'd1020, REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd3002,       10'd1023, REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_MULTIPLIER, 16'h8000, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_OFFSET,     16'h8000, NO_TEMP},
    '{ROW_PRED,  32'd4003,       10'd1000, REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd5004,       10'd2,    REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_IGNORE,     16'h0001, NO_TEMP},
    '{ROW_PRED,  32'd6005,       10'd0,    REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_PRED,  32'd7006,       10'd1023, REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_NONE,       16'hFFFF, NO_TEMP},
    '{ROW_PRED,  32'd8007,       10'd512,  REG_NONE,       16'h0000, NO_TEMP},
    '{ROW_CFG,   32'd0,          10'd0,    REG_IGNORE,     16'hFFFE, NO_TEMP},
    '{ROW_PRED,  32'd9008,       10'd3,    REG_NONE,       16'h0000, NO_TEMP}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  tml_in_if  reading_if ();
  tml_out_if result_if ();

  thermistor_median_log_temperature dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .reading   (reading_if),
    .result    (result_if)
  );

  always #5 clk = ~clk;

  // predictor state
  int                      ln_milli_tab [LN_DEPTH];
  logic signed [REG_W-1:0] gain_q;
  logic signed [REG_W-1:0] offset_q;
  logic                    ignore_q;
  logic [TIME_W-1:0]       last_read_ms;
  logic [SAMPLE_W-1:0]     win_q [WINDOW];
  int                      win_fill;
  int                      win_ptr;

  temp_result_t pending_temps [$];

  int  fail_count = 0;
  int  readings_sent = 0;
  int  temps_checked = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  stall_long = 1'b0;

  // 2*atanh(a/b), Q52
  function automatic u64_t atanh2_fx(input u64_t a, input u64_t b);
    u64_t t;
    u64_t acc;
    u64_t d;
    t = (a << 52) / b;
    acc = 0;
    d = 1;
    while (t != 0) begin
      acc += t / d;
      t = (t * a) / b;
      t = (t * a) / b;
      d += 2;
    end
    return acc * 2;
  endfunction

  function automatic bit convert_reading(input logic [TIME_W-1:0] now,
                                         input logic [SAMPLE_W-1:0] smp,
                                         output temp_result_t r);
    logic [TIME_W-1:0]       delta;
    logic [SAMPLE_W-1:0]     srt [WINDOW];
    logic [SAMPLE_W-1:0]     v;
    logic [SAMPLE_W-1:0]     med;
    logic signed [REG_W-1:0] wrapped;
    int j;
    int scaled;
    int temp;
    r = '0;
    delta = now - last_read_ms;
    if (delta <= READ_GAP) return 1'b0;
    last_read_ms = now;
    win_q[win_ptr] = smp;
    win_ptr = (win_ptr + 1 >= WINDOW) ? 0 : win_ptr + 1;
    if (win_fill < WINDOW) win_fill++;
    for (int i = 0; i < win_fill; i++) srt[i] = win_q[i];
    for (int i = 1; i < win_fill; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    med = srt[win_fill / 2];
    scaled = (ln_milli_tab[med] * int'(gain_q)) / 10000 + int'(offset_q);
    wrapped = scaled[REG_W-1:0];
    temp = int'(wrapped) * 10;
    r.sensor_error = (smp < ERR_LOW) || (smp > ERR_HIGH);
    if (ignore_q) begin
      temp = IGNORE_TEMP;
      r.sensor_error = 1'b0;
    end
    r.milli_celsius = temp[TEMP_W-1:0];
    r.median_sample = med;
    return 1'b1;
  endfunction

  function automatic logic [REG_W-1:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_reading(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] smp,
                              input row_kind_t kind, input temp_result_t typed);
    temp_result_t pred;
    bit has;
    reading_if.valid      <= 1'b1;
    reading_if.now_ms     <= now;
    reading_if.adc_sample <= smp;
    @(posedge clk);
    while (!reading_if.ready) @(posedge clk);
    has = convert_reading(now, smp, pred);
    if (kind == ROW_TYPED) pending_temps.push_back(typed);
    else if (kind == ROW_PRED && has) pending_temps.push_back(pred);
    readings_sent++;
  endtask

  task automatic tx_pause();
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      reading_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // only while idle: drain results, let the controller settle, then write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    reading_if.valid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MULTIPLIER: gain_q = data;
      REG_OFFSET:     offset_q = data;
      REG_IGNORE:     ignore_q = data[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  initial begin : stimulus
    temp_result_t      no_exp;
    logic [TIME_W-1:0] now;
    logic [SAMPLE_W-1:0] smp;
    logic [REG_W-1:0]  g;
    logic [REG_W-1:0]  o;
    logic [REG_W-1:0]  ign_word;
    u64_t  ln2_fx;
    u64_t  p;
    longint acc;
    int    k;
    int    sel;

    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_MULTIPLIER;
    cfg_data              <= '0;
    reading_if.valid      <= 1'b0;
    reading_if.now_ms     <= '0;
    reading_if.adc_sample <= '0;
    no_exp = NO_TEMP;

    // floor(1000 * ln(n)); n = 0 maps to n = 1
    ln2_fx = atanh2_fx(1, 3);
    ln_milli_tab[0] = 0;
    for (int n = 1; n < LN_DEPTH; n++) begin
      k = 0;
      while (k < 12 && 2 * n >= 3 * (1 << k)) k++;
      p = u64_t'(1) << k;
      acc = longint'(ln2_fx * u64_t'(k));
      if (u64_t'(n) >= p) acc = acc + longint'(atanh2_fx(u64_t'(n) - p, u64_t'(n) + p));
      else acc = acc - longint'(atanh2_fx(p - u64_t'(n), u64_t'(n) + p));
      if (acc < 0) acc = 0;
      ln_milli_tab[n] = int'(((u64_t'(acc) >> 4) * 1000) >> 48);
    end

    gain_q = MULT_RESET;
    offset_q = '0;
    ignore_q = 1'b0;
    last_read_ms = '0;
    win_fill = 0;
    win_ptr = 0;
    foreach (win_q[i]) win_q[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        tx_pause();
        send_reading(plan[i].now, plan[i].sample, plan[i].kind, plan[i].typed);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      tx_idle_on = (ph != 2) && (ph != N_PHASES - 1);
      rx_idle_on = (ph != 6) && (ph != N_PHASES - 1);
      case (ph)
        1: begin
          g = 16'h7FFF;
          o = 16'h7FFF;
          ign_word = 16'h0000;
        end
        2: begin
          g = 16'h8000;
          o = 16'h8000;
          ign_word = 16'hFFFE;
        end
        4: begin
          g = pick_reg_value();
          o = pick_reg_value();
          ign_word = 16'($urandom) | 16'h0001;
        end
        default: begin
          g = pick_reg_value();
          o = pick_reg_value();
          ign_word = 16'($urandom) & 16'hFFFE;
        end
      endcase
      write_reg(REG_MULTIPLIER, g);
      write_reg(REG_OFFSET, o);
      write_reg(REG_IGNORE, ign_word);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 20) stall_long = 1'b1;
        if (ph == 5 && n == 80) begin
          reading_if.valid <= 1'b0;
          do @(posedge clk); while (pending_temps.size() != 0);
        end else begin
          tx_pause();
        end

        sel = $urandom_range(0, 99);
        if (sel < 70) now = last_read_ms + 32'd1001 + 32'($urandom_range(0, 3000));
        else if (sel < 85) now = last_read_ms + 32'($urandom_range(0, 1000));
        else if (sel < 90) now = last_read_ms + 32'($urandom_range(1000, 1001));
        else if (sel < 93) now = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
        else now = $urandom();

        case ($urandom_range(0, 9))
          0: smp = 10'($urandom_range(0, 6));
          1: smp = 10'($urandom_range(1017, 1023));
          default: smp = 10'($urandom_range(0, 1023));
        endcase
        send_reading(now, smp, ROW_PRED, no_exp);
      end
    end

    reading_if.valid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Summary: %0d readings sent, %0d temperature beats checked, %0d register writes",
             readings_sent, temps_checked, cfg_writes);
    $display("Summary: gain/offset extremes, ignore mode, time wrap, long output stall");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : result_side
    int gap_left;
    int hold_left;
    gap_left = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_long) begin
        hold_left = LONG_HOLD;
        stall_long = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        result_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 17);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : temp_check
    temp_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_temps.size() == 0) begin
        $error("result beat with no reading pending: milli_celsius %0d median %0d",
               $signed(result_if.milli_celsius), result_if.median_sample);
        fail_count++;
      end else begin
        want = pending_temps.pop_front();
        temps_checked++;
        if (result_if.milli_celsius !== want.milli_celsius) begin
          $error("milli_celsius: expected %0d, got %0d",
                 want.milli_celsius, $signed(result_if.milli_celsius));
          fail_count++;
        end
        if (result_if.sensor_error !== want.sensor_error) begin
          $error("sensor_error: expected %0d, got %0d",
                 want.sensor_error, result_if.sensor_error);
          fail_count++;
        end
        if (result_if.median_sample !== want.median_sample) begin
          $error("median_sample: expected %0d, got %0d",
                 want.median_sample, result_if.median_sample);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count <= LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_temps.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
